### rtl/mksm_pkg.sv
`default_nettype none

package mksm_pkg;

  // Request codes carried in req_type.
  typedef enum logic [1:0] {
    REQ_STREAM = 2'd0,
    REQ_LOAD   = 2'd1,
    REQ_CHECK  = 2'd2,
    REQ_CLEAR  = 2'd3
  } req_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic start;
    logic exec;
    logic scan_rd;
    logic scan_cmp;
    logic scan_next;
    logic finish;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic empty;
    logic last_slot;
    logic scan_hit;
  } sts_t;

endpackage

`default_nettype wire

### rtl/multi_keyword_stream_matcher.sv
// A load, check or clear word goes through S_EXEC, then S_FIN registers its result.
// A stream byte visits each loaded slot in turn with one memory read (S_RD) and one
// compare (S_CMP) until a keyword completes; with none loaded it goes to S_FIN.
// One word is worked on at a time; the next is taken once the result is staged.
// Reset clears lengths, progress, match flags and load counters.
`default_nettype none

module multi_keyword_stream_matcher
  import mksm_pkg::*;
#(
  parameter int NUM_PATTERNS = 16,
  parameter int MAX_LEN      = 32
)(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       req_valid,
  output logic            req_stall,
  input  wire logic [1:0] req_type,
  input  wire logic [7:0] data_byte,
  input  wire logic       keyword_end,
  input  wire logic [3:0] slot_select,
  output logic            rsp_valid,
  input  wire logic       rsp_stall,
  output logic            hit,
  output logic [3:0]      hit_slot,
  output logic            flag_value,
  output logic            load_error
);

  cmd_t cmd;
  sts_t sts;

  mksm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req_type  (req_type),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  mksm_dpath #(
    .NUM_PATTERNS (NUM_PATTERNS),
    .MAX_LEN      (MAX_LEN)
  ) u_dpath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .req_type    (req_type),
    .data_byte   (data_byte),
    .keyword_end (keyword_end),
    .slot_select (slot_select),
    .hit         (hit),
    .hit_slot    (hit_slot),
    .flag_value  (flag_value),
    .load_error  (load_error)
  );

endmodule

`default_nettype wire

### rtl/mksm_ctrl.sv
`default_nettype none

module mksm_ctrl
  import mksm_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       req_valid,
  output logic            req_stall,
  input  wire logic [1:0] req_type,
  output logic            rsp_valid,
  input  wire logic       rsp_stall,
  input  wire sts_t       sts,
  output cmd_t            cmd
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_EXEC = 5'b00010,
    S_RD   = 5'b00100,
    S_CMP  = 5'b01000,
    S_FIN  = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;
  logic   rsp_valid_next;

  assign req_stall = (state != S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.start = 1'b1;
          if (req_type == REQ_STREAM) begin
            state_next = sts.empty ? S_FIN : S_RD;
          end else begin
            state_next = S_EXEC;
          end
        end
      end
      S_EXEC: begin
        cmd.exec   = 1'b1;
        state_next = S_FIN;
      end
      S_RD: begin
        cmd.scan_rd = 1'b1;
        state_next  = S_CMP;
      end
      S_CMP: begin
        cmd.scan_cmp = 1'b1;
        if (sts.scan_hit || sts.last_slot) begin
          state_next = S_FIN;
        end else begin
          cmd.scan_next = 1'b1;
          state_next    = S_RD;
        end
      end
      S_FIN: begin
        // The result moves out only once the output register is free.
        if (!rsp_valid || !rsp_stall) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.finish) begin
      rsp_valid_next = 1'b1;
    end else begin
      rsp_valid_next = rsp_valid && rsp_stall;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      rsp_valid <= rsp_valid_next;
    end
  end

endmodule

`default_nettype wire

### rtl/mksm_dpath.sv
`default_nettype none

module mksm_dpath
  import mksm_pkg::*;
#(
  parameter int NUM_PATTERNS = 16,
  parameter int MAX_LEN      = 32
)(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire cmd_t       cmd,
  output sts_t            sts,
  input  wire logic [1:0] req_type,
  input  wire logic [7:0] data_byte,
  input  wire logic       keyword_end,
  input  wire logic [3:0] slot_select,
  output logic            hit,
  output logic [3:0]      hit_slot,
  output logic            flag_value,
  output logic            load_error
);

  localparam int SW    = (NUM_PATTERNS > 1) ? $clog2(NUM_PATTERNS) : 1;
  localparam int CW    = $clog2(NUM_PATTERNS + 1);
  localparam int LW    = $clog2(MAX_LEN + 1);
  localparam int DEPTH = NUM_PATTERNS * MAX_LEN;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [AW-1:0] MAX_LEN_A  = AW'(MAX_LEN);
  localparam logic [LW-1:0] MAX_LEN_L  = LW'(MAX_LEN);
  localparam logic [CW-1:0] NUM_PAT_C  = CW'(NUM_PATTERNS);

  // Keyword bytes, one row of MAX_LEN bytes per slot.
  logic [7:0] store [DEPTH];
  logic [7:0] rd_data;

  logic [LW-1:0]           kw_len   [NUM_PATTERNS];
  logic [LW-1:0]           progress [NUM_PATTERNS];
  logic [NUM_PATTERNS-1:0] flags;
  logic [CW-1:0]           loaded_count;
  logic [LW-1:0]           load_position;
  logic [SW-1:0]           idx;

  req_t       req_q;
  logic [7:0] byte_q;
  logic       last_q;
  logic [3:0] sel_q;

  logic       res_hit;
  logic [3:0] res_slot;
  logic       res_flag;
  logic       res_err;

  logic          full;
  logic          too_long;
  logic [SW-1:0] load_slot;
  logic [LW-1:0] lp_new;
  logic [AW-1:0] wr_addr;
  logic [AW-1:0] rd_addr;
  logic          sel_ok;
  logic [SW-1:0] sel_idx;
  logic [LW-1:0] cur_len;
  logic [LW-1:0] cur_pos;
  logic [LW-1:0] pos_new;
  logic          slot_active;

  assign full      = (loaded_count == NUM_PAT_C);
  assign too_long  = (load_position == MAX_LEN_L);
  assign load_slot = loaded_count[SW-1:0];
  assign lp_new    = too_long ? load_position : load_position + LW'(1);
  assign wr_addr   = AW'(load_slot) * MAX_LEN_A + AW'(load_position);

  assign cur_len     = kw_len[idx];
  assign cur_pos     = progress[idx];
  assign rd_addr     = AW'(idx) * MAX_LEN_A + AW'(cur_pos);
  assign slot_active = (cur_len != '0);

  // The byte that breaks a partial match is not tried again at position 0.
  assign pos_new = ((cur_pos < cur_len) && (rd_data == byte_q)) ?
                   cur_pos + LW'(1) : '0;

  assign sel_ok  = (int'(sel_q) < NUM_PATTERNS);
  assign sel_idx = SW'(sel_q);

  assign sts.empty     = (loaded_count == '0);
  assign sts.last_slot = ((CW+1)'(idx) + (CW+1)'(1)) >= (CW+1)'(loaded_count);
  assign sts.scan_hit  = slot_active && (pos_new == cur_len);

  always_ff @(posedge clk) begin
    if (cmd.exec && (req_q == REQ_LOAD) && !full && !too_long) begin
      store[wr_addr] <= byte_q;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_rd) begin
      rd_data <= store[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      req_q  <= req_t'(req_type);
      byte_q <= data_byte;
      last_q <= keyword_end;
      sel_q  <= slot_select;
    end
    if (cmd.start) begin
      idx <= '0;
    end else if (cmd.scan_next) begin
      idx <= idx + SW'(1);
    end
    if (cmd.finish) begin
      hit        <= res_hit;
      hit_slot   <= res_slot;
      flag_value <= res_flag;
      load_error <= res_err;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_PATTERNS; i++) begin
        kw_len[i]   <= '0;
        progress[i] <= '0;
      end
      flags         <= '0;
      loaded_count  <= '0;
      load_position <= '0;
      res_hit       <= 1'b0;
      res_slot      <= '0;
      res_flag      <= 1'b0;
      res_err       <= 1'b0;
    end else begin
      if (cmd.start) begin
        res_hit  <= 1'b0;
        res_slot <= '0;
        res_flag <= 1'b0;
        res_err  <= 1'b0;
      end
      if (cmd.exec) begin
        unique case (req_q)
          REQ_LOAD: begin
            if (full) begin
              res_err <= 1'b1;
            end else begin
              if (too_long) begin
                res_err <= 1'b1;
              end
              if (last_q) begin
                kw_len[load_slot]   <= lp_new;
                progress[load_slot] <= '0;
                flags[load_slot]    <= 1'b0;
                loaded_count        <= loaded_count + CW'(1);
                load_position       <= '0;
              end else begin
                load_position <= lp_new;
              end
            end
          end
          REQ_CHECK: begin
            if (sel_ok) begin
              res_flag       <= flags[sel_idx];
              flags[sel_idx] <= 1'b0;
            end
          end
          REQ_CLEAR: begin
            flags <= '0;
          end
          REQ_STREAM: begin
          end
          default: begin
          end
        endcase
      end
      if (cmd.scan_cmp && slot_active) begin
        // A completed keyword clears every slot's progress.
        if (sts.scan_hit) begin
          for (int i = 0; i < NUM_PATTERNS; i++) begin
            progress[i] <= '0;
          end
          flags[idx] <= 1'b1;
          res_hit    <= 1'b1;
          res_slot   <= 4'(idx);
        end else begin
          progress[idx] <= pos_new;
        end
      end
    end
  end

endmodule

`default_nettype wire
